// ===== sv/swrb_pkg.sv =====
// swrb_pkg: shared constants, codes and types for the sliding window retry budget
// no dependencies; used by every module of the block
`default_nettype none

package swrb_pkg;

    // default values for the top level parameters
    localparam int DEF_FIFO_DEPTH          = 256;
    localparam int DEF_TIME_BITS           = 32;
    localparam int DEF_RATIO_FRACTION_BITS = 8;

    // fixed field widths
    localparam int OP_W        = 2;
    localparam int WINDOW_W    = 31;
    localparam int RATIO_W     = 16;
    localparam int MIN_W       = 9;
    localparam int COUNT_W     = 9;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 31;

    // operation codes
    localparam logic [OP_W-1:0] OP_REQUEST = 2'd0;
    localparam logic [OP_W-1:0] OP_RETRY   = 2'd1;
    localparam logic [OP_W-1:0] OP_OBSERVE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RATIO  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_MIN    = 2'd2;

    // configuration reset values
    localparam logic [WINDOW_W-1:0] RST_WINDOW = 31'd1000000;
    localparam logic [RATIO_W-1:0]  RST_RATIO  = 16'd26;
    localparam logic [MIN_W-1:0]    RST_MIN    = 9'd10;

    // per fifo control from the sequencer
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/swrb_fifo.sv =====
// swrb_fifo: timestamp fifo with head and fill tracking and a registered head read
// depends on swrb_pkg (fifo_ctrl_t)
`default_nettype none

module swrb_fifo #(
    parameter int DEPTH     = swrb_pkg::DEF_FIFO_DEPTH,
    parameter int TIME_BITS = swrb_pkg::DEF_TIME_BITS
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire swrb_pkg::fifo_ctrl_t         ctrl,
    input  wire logic [TIME_BITS-1:0]         push_data,
    output logic [$clog2(DEPTH+1)-1:0]        fill,
    output logic [TIME_BITS-1:0]              head_data
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int FILL_W = $clog2(DEPTH + 1);

    logic [TIME_BITS-1:0] mem [DEPTH];
    logic [ADDR_W-1:0]    head_reg;
    logic [ADDR_W-1:0]    head_next;
    logic [ADDR_W-1:0]    tail_reg;
    logic [ADDR_W-1:0]    tail_next;
    logic [FILL_W-1:0]    fill_reg;
    logic [FILL_W-1:0]    fill_next;
    logic [TIME_BITS-1:0] rd_data_reg;

    // pointer advance with wrap at the depth
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (ctrl.pop)
        begin
            head_next = (head_reg == ADDR_W'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (ctrl.push)
        begin
            tail_next = (tail_reg == ADDR_W'(DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (ctrl.push && !ctrl.pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (ctrl.pop && !ctrl.push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    // storage write at the tail
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[tail_reg] <= push_data;
        end
    end

    // registered read of the oldest entry
    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[head_reg];
    end

    assign fill      = fill_reg;
    assign head_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/swrb_age_cmp.sv =====
// swrb_age_cmp: shared modular age subtract and window compare
// depends on swrb_pkg (window width)
`default_nettype none

module swrb_age_cmp #(
    parameter int TIME_BITS = swrb_pkg::DEF_TIME_BITS
) (
    input  wire logic [TIME_BITS-1:0]          now_time,
    input  wire logic [TIME_BITS-1:0]          entry_time,
    input  wire logic [swrb_pkg::WINDOW_W-1:0] window,
    output logic                               expired
);

    localparam int CMP_W = (TIME_BITS > swrb_pkg::WINDOW_W) ? TIME_BITS
                                                             : swrb_pkg::WINDOW_W;

    logic [TIME_BITS-1:0] age;

    // age wraps modulo the timestamp width
    assign age     = now_time - entry_time;
    assign expired = CMP_W'(age) > CMP_W'(window);

endmodule

`default_nettype wire

// ===== sv/sliding_window_retry_budget.sv =====
// sliding_window_retry_budget: retry budget over request and retry timestamp fifos
// steps: request evict, retry evict, limit, apply; each eviction repeats its load and check;
// apply waits for the output slot and no request is taken outside idle; age tests wait on a
// registered memory read and share one age compare, the limit uses one registered multiply
// reset: fifos empty, config registers at defaults, memories are not cleared (no sweep)
// depends on swrb_pkg, swrb_fifo, swrb_age_cmp
`default_nettype none

module sliding_window_retry_budget #(
    parameter int FIFO_DEPTH          = swrb_pkg::DEF_FIFO_DEPTH,
    parameter int TIME_BITS           = swrb_pkg::DEF_TIME_BITS,
    parameter int RATIO_FRACTION_BITS = swrb_pkg::DEF_RATIO_FRACTION_BITS
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration port
    input  wire logic                              cfg_write,
    input  wire logic [swrb_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [swrb_pkg::CFG_DATA_W-1:0]   cfg_data,
    // input channel
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [swrb_pkg::OP_W-1:0]         operation,
    input  wire logic [TIME_BITS-1:0]              now_time,
    // output channel
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic                                   granted,
    output logic [swrb_pkg::COUNT_W-1:0]           request_total,
    output logic [swrb_pkg::COUNT_W-1:0]           retry_total,
    output logic                                   dropped
);

    localparam int FILL_W = $clog2(FIFO_DEPTH + 1);
    localparam int PROD_W = FILL_W + swrb_pkg::RATIO_W;

    localparam logic [2:0] ST_IDLE      = 3'd0;
    localparam logic [2:0] ST_REQ_LOAD  = 3'd1;
    localparam logic [2:0] ST_REQ_CHECK = 3'd2;
    localparam logic [2:0] ST_RTY_LOAD  = 3'd3;
    localparam logic [2:0] ST_RTY_CHECK = 3'd4;
    localparam logic [2:0] ST_LIMIT     = 3'd5;
    localparam logic [2:0] ST_APPLY     = 3'd6;

    logic [2:0]                       state_reg;
    logic [2:0]                       state_next;
    logic [swrb_pkg::WINDOW_W-1:0]    window_reg;
    logic [swrb_pkg::RATIO_W-1:0]     ratio_reg;
    logic [swrb_pkg::MIN_W-1:0]       min_reg;
    logic [swrb_pkg::OP_W-1:0]        op_reg;
    logic [TIME_BITS-1:0]             now_reg;
    logic [PROD_W-1:0]                product_reg;
    logic                             out_valid_reg;
    logic                             granted_reg;
    logic                             dropped_reg;
    logic [swrb_pkg::COUNT_W-1:0]     req_total_reg;
    logic [swrb_pkg::COUNT_W-1:0]     rty_total_reg;

    swrb_pkg::fifo_ctrl_t             req_ctrl;
    swrb_pkg::fifo_ctrl_t             rty_ctrl;
    logic [FILL_W-1:0]                req_fill;
    logic [FILL_W-1:0]                rty_fill;
    logic [TIME_BITS-1:0]             req_head_data;
    logic [TIME_BITS-1:0]             rty_head_data;
    logic [TIME_BITS-1:0]             cmp_entry;
    logic                             expired;

    logic                             in_accept;
    logic                             slot_free;
    logic                             req_full;
    logic [PROD_W-1:0]                share_tokens;
    logic [PROD_W-1:0]                min_ext;
    logic [PROD_W-1:0]                lim_raw;
    logic [PROD_W-1:0]                lim;
    logic                             retry_ok;
    logic                             do_req_push;
    logic                             do_rty_push;
    logic [FILL_W-1:0]                req_count_after;
    logic [FILL_W-1:0]                rty_count_after;

    // request and retry timestamp fifos
    swrb_fifo #(
        .DEPTH     (FIFO_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_req_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (req_ctrl),
        .push_data (now_reg),
        .fill      (req_fill),
        .head_data (req_head_data)
    );

    swrb_fifo #(
        .DEPTH     (FIFO_DEPTH),
        .TIME_BITS (TIME_BITS)
    ) u_rty_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (rty_ctrl),
        .push_data (now_reg),
        .fill      (rty_fill),
        .head_data (rty_head_data)
    );

    // one age compare shared by both fifos
    assign cmp_entry = (state_reg == ST_RTY_CHECK) ? rty_head_data : req_head_data;

    swrb_age_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_age_cmp (
        .now_time   (now_reg),
        .entry_time (cmp_entry),
        .window     (window_reg),
        .expired    (expired)
    );

    // handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign slot_free = !out_valid_reg || !out_stall;

    // retry limit: max(min, tokens) clamped to depth
    assign share_tokens = product_reg >> RATIO_FRACTION_BITS;
    assign min_ext      = PROD_W'(min_reg);
    assign lim_raw      = (share_tokens > min_ext) ? share_tokens : min_ext;
    assign lim          = (lim_raw > PROD_W'(FIFO_DEPTH)) ? PROD_W'(FIFO_DEPTH) : lim_raw;
    assign retry_ok     = PROD_W'(rty_fill) < lim;
    assign req_full     = (req_fill == FILL_W'(FIFO_DEPTH));

    // decision for the current request
    assign do_req_push = (state_reg == ST_APPLY) && slot_free
                         && (op_reg == swrb_pkg::OP_REQUEST) && !req_full;
    assign do_rty_push = (state_reg == ST_APPLY) && slot_free
                         && (op_reg == swrb_pkg::OP_RETRY) && retry_ok;
    assign req_count_after = req_fill + FILL_W'(do_req_push);
    assign rty_count_after = rty_fill + FILL_W'(do_rty_push);

    // fifo controls
    always_comb
    begin
        req_ctrl.push = do_req_push;
        req_ctrl.pop  = (state_reg == ST_REQ_CHECK) && (req_fill != '0) && expired;
        rty_ctrl.push = do_rty_push;
        rty_ctrl.pop  = (state_reg == ST_RTY_CHECK) && (rty_fill != '0) && expired;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_REQ_LOAD;
                end
            end
            ST_REQ_LOAD:
            begin
                state_next = ST_REQ_CHECK;
            end
            ST_REQ_CHECK:
            begin
                state_next = req_ctrl.pop ? ST_REQ_LOAD : ST_RTY_LOAD;
            end
            ST_RTY_LOAD:
            begin
                state_next = ST_RTY_CHECK;
            end
            ST_RTY_CHECK:
            begin
                state_next = rty_ctrl.pop ? ST_RTY_LOAD : ST_LIMIT;
            end
            ST_LIMIT:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= swrb_pkg::RST_WINDOW;
            ratio_reg  <= swrb_pkg::RST_RATIO;
            min_reg    <= swrb_pkg::RST_MIN;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                swrb_pkg::CFG_WINDOW: window_reg <= cfg_data[swrb_pkg::WINDOW_W-1:0];
                swrb_pkg::CFG_RATIO:  ratio_reg  <= cfg_data[swrb_pkg::RATIO_W-1:0];
                swrb_pkg::CFG_MIN:    min_reg    <= cfg_data[swrb_pkg::MIN_W-1:0];
                default:              ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg  <= operation;
            now_reg <= now_time;
        end
    end

    // ratio product, registered ahead of the limit compare
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_LIMIT)
        begin
            product_reg <= PROD_W'(req_fill) * PROD_W'(ratio_reg);
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if ((state_reg == ST_APPLY) && slot_free)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_APPLY) && slot_free)
        begin
            granted_reg   <= do_rty_push;
            dropped_reg   <= (op_reg == swrb_pkg::OP_REQUEST) && req_full;
            req_total_reg <= swrb_pkg::COUNT_W'(req_count_after);
            rty_total_reg <= swrb_pkg::COUNT_W'(rty_count_after);
        end
    end

    assign out_valid     = out_valid_reg;
    assign granted       = granted_reg;
    assign dropped       = dropped_reg;
    assign request_total = req_total_reg;
    assign retry_total   = rty_total_reg;

    // a new result only comes out of the apply step
    a_result_from_apply: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_APPLY)
        else $error("result raised outside the apply step");

    // eviction never pops an empty fifo
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (req_ctrl.pop || rty_ctrl.pop) |->
            ((!req_ctrl.pop || req_fill != '0) && (!rty_ctrl.pop || rty_fill != '0)))
        else $error("pop from an empty fifo");

    // the limit clamp keeps the retry fifo from overflowing
    a_retry_room: assert property (@(posedge clk) disable iff (!rst_n)
        rty_ctrl.push |-> rty_fill < FILL_W'(FIFO_DEPTH))
        else $error("retry push into a full fifo");

    // a granted retry leaves the retry fifo one entry fuller
    a_grant_fill: assert property (@(posedge clk) disable iff (!rst_n)
        rty_ctrl.push |=> rty_fill == $past(rty_fill) + 1'b1)
        else $error("retry fill did not advance on grant");

endmodule

`default_nettype wire

// ===== tb/sliding_window_retry_budget_test.sv =====
// sliding_window_retry_budget_test: self-checking bench for the retry budget block
// predicts the fifo counts and grants per request, checks every result in order
// depends on swrb_pkg and sliding_window_retry_budget
`timescale 1ns / 100ps

module sliding_window_retry_budget_test;

    localparam int DEPTH        = swrb_pkg::DEF_FIFO_DEPTH;
    localparam int TICK_W       = swrb_pkg::DEF_TIME_BITS;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int PEND_SLOTS   = 8;
    localparam logic [swrb_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic                         granted;
        logic [swrb_pkg::COUNT_W-1:0] request_total;
        logic [swrb_pkg::COUNT_W-1:0] retry_total;
        logic                         dropped;
    } budget_result_t;

    // budget tracker: own copy of both timestamp fifos and the config
    class budget_tracker;
        logic [TICK_W-1:0]             stamp [2][DEPTH];
        int unsigned                   head [2];
        int unsigned                   fill [2];
        logic [swrb_pkg::WINDOW_W-1:0] window_ticks;
        logic [swrb_pkg::RATIO_W-1:0]  ratio_q8;
        logic [swrb_pkg::MIN_W-1:0]    floor_tokens;
        budget_result_t                pending_ring [PEND_SLOTS];
        int unsigned                   noted_count;
        int unsigned                   checked_count;
        int                            errors;

        function new();
            head          = '{0, 0};
            fill          = '{0, 0};
            window_ticks  = swrb_pkg::RST_WINDOW;
            ratio_q8      = swrb_pkg::RST_RATIO;
            floor_tokens  = swrb_pkg::RST_MIN;
            noted_count   = 0;
            checked_count = 0;
            errors        = 0;
        endfunction

        function void write_reg(logic [swrb_pkg::CFG_INDEX_W-1:0] idx,
                                logic [swrb_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                swrb_pkg::CFG_WINDOW: window_ticks = data[swrb_pkg::WINDOW_W-1:0];
                swrb_pkg::CFG_RATIO:  ratio_q8 = data[swrb_pkg::RATIO_W-1:0];
                swrb_pkg::CFG_MIN:    floor_tokens = data[swrb_pkg::MIN_W-1:0];
                default:              ;
            endcase
        endfunction

        // pop entries whose wrapped age is beyond the window
        function void age_out(int sel, logic [TICK_W-1:0] now_tick);
            while (fill[sel] > 0 &&
                   (now_tick - stamp[sel][head[sel]]) > {1'b0, window_ticks})
            begin
                head[sel] = (head[sel] + 1) % DEPTH;
                fill[sel]--;
            end
        endfunction

        function void push(int sel, logic [TICK_W-1:0] now_tick);
            stamp[sel][(head[sel] + fill[sel]) % DEPTH] = now_tick;
            fill[sel]++;
        endfunction

        // max of floor and ratio share of requests, never above the fifo depth
        function int unsigned retry_cap();
            int unsigned by_ratio;
            int unsigned cap;
            by_ratio = (fill[0] * ratio_q8) >> swrb_pkg::DEF_RATIO_FRACTION_BITS;
            cap = (by_ratio > floor_tokens) ? by_ratio : floor_tokens;
            if (cap > DEPTH)
                cap = DEPTH;
            return cap;
        endfunction

        // work out the totals for one accepted request
        function void note_request(logic [swrb_pkg::OP_W-1:0] op,
                                   logic [TICK_W-1:0] now_tick);
            budget_result_t res;
            res = '0;
            age_out(0, now_tick);
            age_out(1, now_tick);
            case (op)
                swrb_pkg::OP_REQUEST:
                    if (fill[0] >= DEPTH)
                        res.dropped = 1'b1;
                    else
                        push(0, now_tick);
                swrb_pkg::OP_RETRY:
                    if (fill[1] < retry_cap())
                    begin
                        push(1, now_tick);
                        res.granted = 1'b1;
                    end
                default: ;
            endcase
            res.request_total = swrb_pkg::COUNT_W'(fill[0]);
            res.retry_total   = swrb_pkg::COUNT_W'(fill[1]);
            if (noted_count - checked_count >= PEND_SLOTS)
            begin
                $display("%0t: more than %0d results outstanding", $time, PEND_SLOTS);
                errors++;
            end
            pending_ring[noted_count % PEND_SLOTS] = res;
            noted_count++;
        endfunction

        function void compare_field(string label, logic [swrb_pkg::COUNT_W-1:0] want,
                                    logic [swrb_pkg::COUNT_W-1:0] got);
            if (got !== want)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, label, want, got);
                errors++;
            end
        endfunction

        // compare one result with the oldest prediction
        function void check_result(budget_result_t got);
            budget_result_t want;
            if (noted_count == checked_count)
            begin
                $display("%0t: unexpected result granted %0d request_total %0d",
                         $time, got.granted, got.request_total);
                $display("%0t: unexpected result retry_total %0d dropped %0d",
                         $time, got.retry_total, got.dropped);
                errors++;
                return;
            end
            want = pending_ring[checked_count % PEND_SLOTS];
            checked_count++;
            compare_field("granted", want.granted, got.granted);
            compare_field("request_total", want.request_total, got.request_total);
            compare_field("retry_total", want.retry_total, got.retry_total);
            compare_field("dropped", want.dropped, got.dropped);
        endfunction

        function int pending();
            return int'(noted_count - checked_count);
        endfunction
    endclass

    logic                             clk;
    logic                             rst_n;
    logic                             cfg_write;
    logic [swrb_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [swrb_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                             in_valid;
    logic                             in_stall;
    logic [swrb_pkg::OP_W-1:0]        operation;
    logic [TICK_W-1:0]                now_time;
    logic                             out_valid;
    logic                             out_stall;
    logic                             granted;
    logic [swrb_pkg::COUNT_W-1:0]     request_total;
    logic [swrb_pkg::COUNT_W-1:0]     retry_total;
    logic                             dropped;

    budget_tracker     tracker;
    int                cycle_count = 0;
    int                items_sent = 0;
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_left = 0;
    bit                hold_wanted = 1'b0;
    bit                hold_taken = 1'b0;
    logic [TICK_W-1:0] clock_tick = '0;

    sliding_window_retry_budget uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .now_time      (now_time),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .granted       (granted),
        .request_total (request_total),
        .retry_total   (retry_total),
        .dropped       (dropped)
    );

    always #2 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // result checking
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result({granted, request_total, retry_total, dropped});
    end

    // receiver: random stalls, or a long hold-off when asked
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_wanted && !hold_taken)
            begin
                hold_left = HOLD_CYCLES;
                hold_taken = 1'b1;
            end
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left--;
            end
            else
                out_stall = ($urandom_range(99) < recv_idle_pct);
        end
    end

    // offer one request and wait until the block takes it
    task automatic offer(logic [swrb_pkg::OP_W-1:0] op, logic [TICK_W-1:0] tick);
        if (items_sent < 600)
        begin
            send_idle_pct = 33;
            recv_idle_pct = 47;
        end
        else if (items_sent < 1200)
        begin
            send_idle_pct = 47;
            recv_idle_pct = 33;
        end
        else
        begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        while ($urandom_range(99) < send_idle_pct)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
        @(negedge clk);
        in_valid  = 1'b1;
        operation = op;
        now_time  = tick;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.note_request(op, tick);
        items_sent++;
    endtask

    // stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [swrb_pkg::CFG_INDEX_W-1:0] idx,
                             logic [swrb_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        tracker.write_reg(idx, data);
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    // one random phase under one budget setting
    task automatic run_phase(logic [swrb_pkg::WINDOW_W-1:0] window,
                             logic [swrb_pkg::RATIO_W-1:0] ratio,
                             logic [swrb_pkg::MIN_W-1:0] floor_tokens, int items,
                             int req_pct, int retry_pct, int step_max, int jump_pct,
                             bit long_hold, bit pause_mid);
        logic [swrb_pkg::OP_W-1:0] op;
        int                        pick;
        drain();
        write_reg(swrb_pkg::CFG_WINDOW, swrb_pkg::CFG_DATA_W'(window));
        write_reg(swrb_pkg::CFG_RATIO, swrb_pkg::CFG_DATA_W'(ratio));
        write_reg(swrb_pkg::CFG_MIN, swrb_pkg::CFG_DATA_W'(floor_tokens));
        for (int n = 0; n < items; n++)
        begin
            pick = $urandom_range(99);
            if (pick < req_pct)
                op = swrb_pkg::OP_REQUEST;
            else if (pick < req_pct + retry_pct)
                op = swrb_pkg::OP_RETRY;
            else
                op = $urandom_range(1) ? swrb_pkg::OP_OBSERVE : OP_UNUSED;
            if ($urandom_range(99) < jump_pct)
                clock_tick += $urandom();
            else
                clock_tick += $urandom_range(step_max);
            offer(op, clock_tick);
            // back-pressure from the receiver while requests keep coming
            if (long_hold && n == items / 3)
                hold_wanted = 1'b1;
            if (pause_mid && n == items / 2)
                drain();
        end
    endtask

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = swrb_pkg::CFG_WINDOW;
        cfg_data  = '0;
        in_valid  = 1'b0;
        operation = swrb_pkg::OP_REQUEST;
        now_time  = '0;
        tracker   = new();
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: every operation, retry floor reached, window edge, time wrap
        offer(swrb_pkg::OP_REQUEST, 32'd0);
        offer(swrb_pkg::OP_RETRY, 32'd0);
        offer(swrb_pkg::OP_OBSERVE, 32'd0);
        offer(OP_UNUSED, 32'd0);
        repeat (8) offer(swrb_pkg::OP_RETRY, 32'd999999);
        offer(swrb_pkg::OP_RETRY, 32'd1000000);
        offer(swrb_pkg::OP_RETRY, 32'd1000000);
        offer(swrb_pkg::OP_OBSERVE, 32'd1000001);
        offer(swrb_pkg::OP_REQUEST, 32'hFFFF_FFF0);
        offer(swrb_pkg::OP_REQUEST, 32'hFFFF_FFFF);
        offer(swrb_pkg::OP_RETRY, 32'h0000_0010);
        offer(swrb_pkg::OP_OBSERVE, 32'h7FFF_FFFF);
        clock_tick = 32'h7FFF_FFFF;

        // zero window: only same-tick entries survive
        run_phase(31'd0, 16'd256, 9'd0, 60, 40, 40, 1, 0, 1'b0, 1'b0);
        // no retry budget at all
        run_phase(31'd1, 16'd0, 9'd0, 100, 40, 40, 2, 0, 1'b0, 1'b0);
        // widest window and largest ratio: both fifos fill, requests drop
        run_phase(31'h7FFF_FFFF, 16'hFFFF, 9'd256, 600, 55, 45, 3, 0, 1'b1, 1'b0);
        // short window, steady eviction
        run_phase(31'd500, 16'd128, 9'd3, 350, 45, 35, 60, 1, 1'b0, 1'b1);
        run_phase(31'd5000, 16'd26, 9'd255, 250, 40, 40, 200, 2, 1'b0, 1'b0);
        // tiny ratio: grants only with a full request fifo
        run_phase(31'd1000000, 16'd1, 9'd0, 360, 85, 12, 1, 0, 1'b0, 1'b0);
        run_phase(swrb_pkg::WINDOW_W'($urandom_range(32'h7FFF_FFFF, 1)),
                  swrb_pkg::RATIO_W'($urandom_range(65535)),
                  swrb_pkg::MIN_W'($urandom_range(256)), 200, 40, 40, 1000, 5,
                  1'b0, 1'b0);

        drain();
        if (tracker.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/swrb_pkg.sv
sv/swrb_fifo.sv
sv/swrb_age_cmp.sv
sv/sliding_window_retry_budget.sv
tb/sliding_window_retry_budget_test.sv
